// File: rtl/core/backslash_escape_decoder_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the backslash escape decoder
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define BED_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bed_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bed_pkg
// Shared types and constants of the backslash escape decoder.
// ---------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U_LO  = 8'h75;
  localparam logic [7:0] CH_U_UP  = 8'h55;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       error;
  } out_item_t;

  // one classified operation: one result, or two when two_res is set
  typedef struct packed {
    logic       two_res;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
    logic       eos;
    logic       err;
  } op_t;

  typedef struct packed {
    logic first_half;
  } back_status_t;

endpackage

// File: rtl/core/backslash_escape_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// backslash_escape_decoder_unit
// Streaming unescaper for backslash-escaped strings, queue-style ports.
// ---------------------------------------------------------------------------
// The decoder takes one byte of an escaped string per cycle while full is
// low and gives the unescaped bytes in order. Both sides are queues: push
// while full is low, pop while empty is low. A byte is parsed the cycle it
// is transferred in; the parser issues at most one operation per byte into a
// short register queue (QUEUE_DEPTH entries), and the expander drains it at
// one result per cycle while pop is high. Most bytes give at most one result,
// so input and output both run at one transfer per cycle when neither side
// stalls. A u escape whose high byte is nonzero gives two results and holds
// the expander for both of them; the queue soaks this up and full rises only
// when the expander falls QUEUE_DEPTH operations behind. Each operation is
// registered in the queue before its result appears. An error result carries
// out_byte zero and end_of_string set; the rest of that string is swallowed
// without results. Results are read straight off the queue head register.
// ---------------------------------------------------------------------------
`include "backslash_escape_decoder_unit_macros.svh"

module backslash_escape_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = bed_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  bed_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output bed_pkg::out_item_t out_item_o
);
  import bed_pkg::*;

  // parser -> queue
  logic         op_valid;
  op_t          op;
  // queue -> expander
  op_t          head;
  logic         q_empty;
  logic         deq;
  back_status_t back_status;
  // high byte of a pair is on the result ports
  logic         pair_hi;

  // front: classifies each byte, keeps the escape state
  bed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .op_valid_o (op_valid),
    .op_o       (op)
  );

  // decoupling queue; its full flag is the input-side backpressure
  bed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (op_valid),
    .wr_op_i (op),
    .rd_en_i (deq),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (full)
  );

  // back: splits two-byte operations into two result transfers
  bed_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (q_empty),
    .pop          (pop),
    .empty        (empty),
    .out_item_o   (out_item_o),
    .deq_o        (deq),
    .status_o     (back_status)
  );

  assign pair_hi = back_status.first_half;

  // error results are always zero-byte, string-ending
  `BED_ASSERT_IMPL(a_err_byte, !empty && out_item_o.error, out_item_o.out_byte == '0, "err byte")
  `BED_ASSERT_IMPL(a_err_eos, !empty && out_item_o.error, out_item_o.end_of_string, "err eos")
  // the high byte of a pair is taken, so the low byte must follow at once
  `BED_ASSERT_NEXT(a_pair_follows, pop && pair_hi, !empty && !pair_hi, "pair broken")
  // a full queue can never look empty on the result side
  `BED_ASSERT_IMPL(a_full_not_empty, full, !empty, "queue full yet empty")

endmodule

// File: rtl/core/bed_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bed_front
// Escape parser: takes input bytes and issues classified operations.
// ---------------------------------------------------------------------------
module bed_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  bed_pkg::in_item_t in_item_i,
  output logic              op_valid_o,
  output bed_pkg::op_t      op_o
);
  import bed_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_DROP
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [11:0] acc_q, acc_d;
  logic        accept;
  logic [4:0]  hex;
  logic [7:0]  c;
  logic        last;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h00;
    if (ch >= 8'h30 && ch <= 8'h39) r = {1'b1, 4'(ch - 8'h30)};
    else if (ch >= 8'h61 && ch <= 8'h66) r = {1'b1, 4'(ch - 8'h57)};
    else if (ch >= 8'h41 && ch <= 8'h46) r = {1'b1, 4'(ch - 8'h37)};
    return r;
  endfunction

  function automatic op_t single(input logic [7:0] b, input logic eos);
    op_t o;
    o = '0;
    o.lo_byte = b;
    o.eos     = eos;
    return o;
  endfunction

  function automatic op_t err_op();
    op_t o;
    o = '0;
    o.eos = 1'b1;
    o.err = 1'b1;
    return o;
  endfunction

  assign accept = push && !full;
  assign c      = in_item_i.in_byte;
  assign last   = in_item_i.last;
  assign hex    = hex_decode(c);

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    op_valid_o = 1'b0;
    op_o       = single(c, last);
    if (accept) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (c == CH_BSL) begin
            if (last) begin
              op_valid_o = 1'b1;
              op_o       = err_op();
            end else begin
              mode_d = MODE_ESCAPE;
            end
          end else begin
            op_valid_o = 1'b1;
          end
        end
        MODE_ESCAPE: begin
          mode_d     = MODE_NORMAL;
          op_valid_o = 1'b1;
          unique case (c) inside
            CH_BSL, CH_QUOTE, CH_APOS: op_o = single(c, last);
            CH_T: op_o = single(CH_TAB, last);
            CH_N: op_o = single(CH_LF, last);
            CH_R: op_o = single(CH_CR, last);
            CH_U_LO, CH_U_UP: begin
              cnt_d = '0;
              acc_d = '0;
              if (last) begin
                op_o = err_op();
              end else begin
                mode_d     = MODE_HEX;
                op_valid_o = 1'b0;
              end
            end
            default: begin
              op_o   = err_op();
              mode_d = last ? MODE_NORMAL : MODE_DROP;
              cnt_d  = '0;
              acc_d  = '0;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hex[4]) begin
            op_valid_o = 1'b1;
            op_o       = err_op();
            mode_d     = last ? MODE_NORMAL : MODE_DROP;
            cnt_d      = '0;
            acc_d      = '0;
          end else if (cnt_q != 2'd3) begin
            acc_d = {acc_q[7:0], hex[3:0]};
            cnt_d = cnt_q + 2'd1;
            if (last) begin
              // string ended inside the hex digits
              op_valid_o = 1'b1;
              op_o       = err_op();
              mode_d     = MODE_NORMAL;
              cnt_d      = '0;
              acc_d      = '0;
            end
          end else begin
            op_valid_o   = 1'b1;
            op_o         = '0;
            op_o.hi_byte = acc_q[11:4];
            op_o.lo_byte = {acc_q[3:0], hex[3:0]};
            op_o.two_res = (acc_q[11:4] != 8'h00);
            op_o.eos     = last;
            mode_d       = MODE_NORMAL;
            cnt_d        = '0;
            acc_d        = '0;
          end
        end
        MODE_DROP: begin
          if (last) mode_d = MODE_NORMAL;
        end
        default: mode_d = MODE_NORMAL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// File: rtl/core/bed_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bed_queue
// Short register FIFO of operations between parser and expander.
// ---------------------------------------------------------------------------
module bed_queue #(
  parameter int unsigned DEPTH = bed_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  bed_pkg::op_t wr_op_i,
  input  logic         rd_en_i,
  output bed_pkg::op_t head_o,
  output logic         empty_o,
  output logic         full_o
);
  import bed_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_wr, do_rd;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign head_o  = mem_q[rptr_q];
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) wptr_q <= ptr_next(wptr_q);
      if (do_rd) rptr_q <= ptr_next(rptr_q);
      if (do_wr && !do_rd) count_q <= count_q + 1'b1;
      else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
    end
  end

endmodule

// File: rtl/core/bed_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bed_back
// Expander: turns the queue head into one or two result transfers.
// ---------------------------------------------------------------------------
module bed_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bed_pkg::op_t          head_i,
  input  logic                  head_empty_i,
  input  logic                  pop,
  output logic                  empty,
  output bed_pkg::out_item_t    out_item_o,
  output logic                  deq_o,
  output bed_pkg::back_status_t status_o
);
  import bed_pkg::*;

  logic phase_q, phase_d;
  logic first_half;
  logic xfer;

  // first of two results: the high byte, never end of string
  assign first_half = head_i.two_res && !phase_q;
  assign empty      = head_empty_i;
  assign xfer       = pop && !head_empty_i;
  assign deq_o      = xfer && !first_half;

  assign out_item_o.out_byte      = first_half ? head_i.hi_byte : head_i.lo_byte;
  assign out_item_o.end_of_string = first_half ? 1'b0 : head_i.eos;
  assign out_item_o.error         = head_i.err;

  assign status_o.first_half = first_half && !head_empty_i;

  always_comb begin
    phase_d = phase_q;
    if (xfer) phase_d = first_half;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else         phase_q <= phase_d;
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for backslash_escape_decoder_unit. Escaped strings
// are queued up front, offered in bursts by a falling-edge driver, and every
// input transfer runs through a bench-side unescaper that queues the bytes
// the decoder should give. A rising-edge monitor checks each result transfer
// against the oldest of them; the receiver stalls on its own pattern and
// once holds off long enough to back the decoder up to full.
// ---------------------------------------------------------------------------
module tb;
  import bed_pkg::*;

  localparam int unsigned N_ITEMS        = 1850;
  localparam int unsigned HOLD_AT        = 600;   // input transfers before the long hold-off
  localparam int unsigned HOLD_LEN       = 300;   // cycles of the hold-off
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {DM_TEXT, DM_ESC, DM_HEX, DM_DROP} dec_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      push      = 1'b0;
  logic      pop       = 1'b0;
  in_item_t  in_item_i = '0;
  logic      full;
  logic      empty;
  out_item_t out_item_o;

  backslash_escape_decoder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // --- stores ---------------------------------------------------------------
  in_item_t    pend_q[$];     // bytes still to be offered
  out_item_t   unesc_q[$];    // unescaped bytes the decoder owes us
  logic [7:0]  str_q[$];      // string under construction

  int unsigned n_fail   = 0;
  int unsigned n_in     = 0;  // input transfers so far
  int unsigned idle_cyc = 0;
  bit          in_taken = 1'b0;

  // --- unescaper state --------------------------------------------------------
  dec_mode_e   dec_mode = DM_TEXT;
  logic [1:0]  hex_cnt  = '0;
  logic [11:0] hex_acc  = '0;

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void owe(logic [7:0] b, logic eos, logic err);
    out_item_t r;
    r.out_byte      = b;
    r.end_of_string = eos;
    r.error         = err;
    unesc_q.insert(unesc_q.size(), r);
  endfunction

  // error result closes the string; drop the remainder unless this was its end
  function automatic void bad_escape(logic last);
    owe(8'h00, 1'b1, 1'b1);
    dec_mode = last ? DM_TEXT : DM_DROP;
    hex_cnt  = '0;
    hex_acc  = '0;
  endfunction

  function automatic void unescape_byte(in_item_t it);
    int         v;
    logic [7:0] hi;
    logic [7:0] lo;
    case (dec_mode)
      DM_TEXT: begin
        if (it.in_byte == CH_BSL) begin
          if (it.last) bad_escape(it.last);
          else dec_mode = DM_ESC;
        end else begin
          owe(it.in_byte, it.last, 1'b0);
        end
      end
      DM_ESC: begin
        if (it.in_byte == CH_BSL || it.in_byte == CH_QUOTE || it.in_byte == CH_APOS) begin
          owe(it.in_byte, it.last, 1'b0);
          dec_mode = DM_TEXT;
        end else if (it.in_byte == CH_T) begin
          owe(CH_TAB, it.last, 1'b0);
          dec_mode = DM_TEXT;
        end else if (it.in_byte == CH_N) begin
          owe(CH_LF, it.last, 1'b0);
          dec_mode = DM_TEXT;
        end else if (it.in_byte == CH_R) begin
          owe(CH_CR, it.last, 1'b0);
          dec_mode = DM_TEXT;
        end else if (it.in_byte == CH_U_LO || it.in_byte == CH_U_UP) begin
          if (it.last) begin
            bad_escape(it.last);
          end else begin
            dec_mode = DM_HEX;
            hex_cnt  = '0;
            hex_acc  = '0;
          end
        end else begin
          bad_escape(it.last);
        end
      end
      DM_HEX: begin
        v = hex_nibble(it.in_byte);
        if (v < 0) begin
          bad_escape(it.last);
        end else if (hex_cnt != 2'd3) begin
          hex_acc = {hex_acc[7:0], v[3:0]};
          hex_cnt = hex_cnt + 2'd1;
          if (it.last) bad_escape(it.last);
        end else begin
          hi = hex_acc[11:4];
          lo = {hex_acc[3:0], v[3:0]};
          if (hi != 8'h00) owe(hi, 1'b0, 1'b0);
          owe(lo, it.last, 1'b0);
          dec_mode = DM_TEXT;
          hex_cnt  = '0;
          hex_acc  = '0;
        end
      end
      default: begin
        if (it.last) dec_mode = DM_TEXT;
      end
    endcase
  endfunction

  // --- stimulus helpers --------------------------------------------------------
  function automatic void queue_byte(logic [7:0] b, logic last);
    in_item_t it;
    it.in_byte = b;
    it.last    = last;
    pend_q.insert(pend_q.size(), it);
  endfunction

  // append one character to the string under construction
  function automatic void put_char(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  // flush the string under construction, marking its final byte
  function automatic void close_string();
    foreach (str_q[i]) queue_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endfunction

  function automatic logic [7:0] hex_char(int unsigned n);
    if (n < 10) return 8'("0" + n);
    return $urandom_range(1) ? 8'("a" + n - 10) : 8'("A" + n - 10);
  endfunction

  function automatic bit is_esc_letter(logic [7:0] c);
    return c == CH_BSL || c == CH_QUOTE || c == CH_APOS || c == CH_T || c == CH_N ||
           c == CH_R || c == CH_U_LO || c == CH_U_UP;
  endfunction

  function automatic void add_random_string();
    logic [7:0] simple_esc [6] = '{CH_BSL, CH_QUOTE, CH_APOS, CH_T, CH_N, CH_R};
    int unsigned n_tok;
    int unsigned kind;
    int unsigned n_dig;
    logic [7:0]  b;
    bit          stop;
    stop = 1'b0;
    if ($urandom_range(99) < 5) begin
      // raw noise, backslashes and all
      n_tok = $urandom_range(1, 6);
      repeat (n_tok) put_char(8'($urandom_range(255)));
      close_string();
      return;
    end
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok && !stop; t++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        do b = 8'($urandom_range(255)); while (b == CH_BSL);
        put_char(b);
      end else if (kind < 70) begin
        put_char(CH_BSL);
        put_char(simple_esc[$urandom_range(5)]);
      end else if (kind < 93) begin
        put_char(CH_BSL);
        put_char($urandom_range(1) ? CH_U_LO : CH_U_UP);
        // a zero high byte is common in practice and yields a single result
        if ($urandom_range(9) < 3) begin
          put_char("0");
          put_char("0");
        end else begin
          put_char(hex_char($urandom_range(15)));
          put_char(hex_char($urandom_range(15)));
        end
        put_char(hex_char($urandom_range(15)));
        put_char(hex_char($urandom_range(15)));
      end else begin
        put_char(CH_BSL);
        case ($urandom_range(2))
          0: begin
            do b = 8'($urandom_range(255)); while (is_esc_letter(b));
            put_char(b);
          end
          1: begin
            put_char($urandom_range(1) ? CH_U_LO : CH_U_UP);
            n_dig = $urandom_range(3);
            repeat (n_dig) put_char(hex_char($urandom_range(15)));
            do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
            put_char(b);
          end
          default: begin
            // string cut short inside the escape
            if ($urandom_range(3) != 0) begin
              put_char($urandom_range(1) ? CH_U_LO : CH_U_UP);
              n_dig = $urandom_range(3);
              repeat (n_dig) put_char(hex_char($urandom_range(15)));
            end
            stop = 1'b1;
          end
        endcase
      end
    end
    close_string();
  endfunction

  // --- driver: bursts with random gaps, offer held until transferred -------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (gap_left != 0) begin
        push <= 1'b0;
        gap_left--;
      end else if (pend_q.size() != 0) begin
        push      <= 1'b1;
        in_item_i <= pend_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --- receiver: stall rate changes per window, plus one long hold-off -----------
  int unsigned win_left  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(16, 96);
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        win_left--;
      end
      // sender keeps going during the hold-off, so the decoder fills and raises full
      if (!hold_done && n_in >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --- monitor: result check first, then the input transfer of this edge ---------
  always @(posedge clk_i) begin
    out_item_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (unesc_q.size() == 0) begin
          $display("%0t: result with nothing owed: expected none, actual %h", $time,
                   out_item_o);
          n_fail++;
        end else begin
          want = unesc_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_item_o.out_byte);
            n_fail++;
          end
          if (out_item_o.end_of_string !== want.end_of_string) begin
            $display("%0t: end_of_string expected %b actual %b", $time,
                     want.end_of_string, out_item_o.end_of_string);
            n_fail++;
          end
          if (out_item_o.error !== want.error) begin
            $display("%0t: error expected %b actual %b", $time, want.error,
                     out_item_o.error);
            n_fail++;
          end
        end
      end
      if (push && !full) begin
        in_taken = 1'b1;
        unescape_byte(in_item_i);
        void'(pend_q.pop_front());
        n_in++;
      end
      // watchdog: only counts while work is outstanding
      if ((push && !full) || (pop && !empty)) begin
        idle_cyc = 0;
      end else if (pend_q.size() != 0 || unesc_q.size() != 0) begin
        idle_cyc++;
      end
      if (idle_cyc >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cyc);
        $display("backslash_escape_decoder_unit: mismatch");
        $finish;
      end
    end
  end

  // --- sequence ------------------------------------------------------------------
  initial begin
    // plain extremes and every simple escape in one string
    queue_byte(8'h00, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_T, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_N, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_R, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_QUOTE, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_APOS, 1'b0);
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_BSL, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // u escape with nonzero high byte: two results, mixed-case digits
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_U_UP, 1'b0);
    queue_byte("1", 1'b0); queue_byte("2", 1'b0);
    queue_byte("f", 1'b0); queue_byte("F", 1'b1);
    // string ends right after a backslash
    queue_byte(CH_BSL, 1'b1);
    // unknown escape letter mid-string, rest dropped
    queue_byte(CH_BSL, 1'b0); queue_byte("q", 1'b0); queue_byte("Z", 1'b1);
    // non-hex digit inside the u escape
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_U_LO, 1'b0);
    queue_byte("1", 1'b0); queue_byte("g", 1'b1);
    // string ends before all four hex digits
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_U_LO, 1'b0); queue_byte("9", 1'b1);
    // string ends right after u
    queue_byte(CH_BSL, 1'b0); queue_byte(CH_U_UP, 1'b1);

    while (pend_q.size() < N_ITEMS) add_random_string();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0) @(posedge clk_i);
    while (unesc_q.size() != 0) @(posedge clk_i);
    // trailing dropped bytes may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0 && unesc_q.size() == 0) begin
      $display("backslash_escape_decoder_unit: match");
    end else begin
      $display("backslash_escape_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bed_pkg.sv
rtl/core/bed_front.sv
rtl/core/bed_queue.sv
rtl/core/bed_back.sv
rtl/core/backslash_escape_decoder_unit.sv
dv/tb.sv
